// ===== design/qir_pkg.sv =====
// ----------------------------------------------------------------------------
// qir_pkg
// Shared constants, types and helpers of the quadratic interpolated ramp.
// ----------------------------------------------------------------------------
package qir_pkg;

  localparam int ACC_W           = 64;
  localparam int POINT_W         = 24;
  localparam int MID_W           = 25;
  localparam int MID_SHIFT       = 35;
  localparam int DIGIT_W         = 4;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SEG_LEN_RESET   = 441;
  localparam int MIN_LEN         = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_DSTART,
    ST_DIV,
    ST_SAMPLE,
    ST_ACC,
    ST_EMIT
  } qir_state_t;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_RUN,
    SU_FIN
  } qir_unit_state_t;

  typedef enum logic [2:0] {
    AC_IDLE,
    AC_SLOPE,
    AC_SFIX,
    AC_LEVEL,
    AC_LFIX
  } qir_acc_state_t;

  typedef struct packed {
    logic start;
    logic level_ld;
    logic curv_ld;
  } qir_acc_ctl_t;

  function automatic logic [ACC_W-1:0] sat_value(input logic neg);
    sat_value = neg ? ACC_MIN : ACC_MAX;
  endfunction

endpackage

// ===== design/qir_ifs.sv =====
// ----------------------------------------------------------------------------
// qir_ifs
// Valid/ready channels of the ramp: random point in, sample out, length write.
// ----------------------------------------------------------------------------
interface qir_in_if;
  logic                          valid;
  logic                          ready;
  logic [qir_pkg::POINT_W-1:0]   random_point;

  modport source (output valid, output random_point, input ready);
  modport sink   (input valid, input random_point, output ready);
endinterface

interface qir_out_if #(
  parameter int SAMPLE_BITS = qir_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] output_sample;

  modport source (output valid, output output_sample, input ready);
  modport sink   (input valid, input output_sample, output ready);
endinterface

interface qir_cfg_if #(
  parameter int LENGTH_BITS = qir_pkg::LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] segment_length;

  modport source (output valid, output segment_length, input ready);
  modport sink   (input valid, input segment_length, output ready);
endinterface

// ===== design/qir_lenmul.sv =====
// ----------------------------------------------------------------------------
// qir_lenmul
// Bit-serial saturating product of a signed Q4.59 value and a segment length.
// ----------------------------------------------------------------------------
module qir_lenmul #(
  parameter int LENGTH_BITS = qir_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qir_pkg::ACC_W-1:0]  slope,
  input  logic [LENGTH_BITS-1:0]     len,
  output logic                       done,
  output logic [qir_pkg::ACC_W-1:0]  prod
);

  localparam int AW    = qir_pkg::ACC_W;
  localparam int CNT_W = $clog2(LENGTH_BITS);

  qir_pkg::qir_unit_state_t state_r, state_nxt;
  logic [AW-1:0]          mag_r, mag_nxt;
  logic [LENGTH_BITS-1:0] lsr_r, lsr_nxt;
  logic [AW-2:0]          acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]          prod_r, prod_nxt;
  logic                   done_r, done_nxt;
  logic [AW:0]            sum;

  assign sum = {1'b0, acc_r, 1'b0} + (lsr_r[LENGTH_BITS-1] ? {1'b0, mag_r} : '0);

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    lsr_nxt   = lsr_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    done_nxt  = 1'b0;
    case (state_r)
      qir_pkg::SU_IDLE: begin
        if (start) begin
          neg_nxt   = slope[AW-1];
          mag_nxt   = slope[AW-1] ? (~slope + 1'b1) : slope;
          lsr_nxt   = len;
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(LENGTH_BITS - 1);
          state_nxt = qir_pkg::SU_RUN;
        end
      end
      qir_pkg::SU_RUN: begin
        acc_nxt = sum[AW-2:0];
        ovf_nxt = ovf_r | (|sum[AW:AW-1]);
        lsr_nxt = {lsr_r[LENGTH_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = qir_pkg::SU_FIN;
        end
      end
      qir_pkg::SU_FIN: begin
        if (ovf_r) begin
          prod_nxt = qir_pkg::sat_value(neg_r);
        end else if (neg_r) begin
          prod_nxt = ~{1'b0, acc_r} + 1'b1;
        end else begin
          prod_nxt = {1'b0, acc_r};
        end
        done_nxt  = 1'b1;
        state_nxt = qir_pkg::SU_IDLE;
      end
      default: state_nxt = qir_pkg::SU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qir_pkg::SU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    lsr_r  <= lsr_nxt;
    acc_r  <= acc_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== design/qir_div.sv =====
// ----------------------------------------------------------------------------
// qir_div
// Restoring divider, one quotient bit per cycle, signed truncating quotient.
// ----------------------------------------------------------------------------
module qir_div #(
  parameter int DEN_W = 2 * qir_pkg::LENGTH_BITS_DEF - 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qir_pkg::ACC_W-1:0]  num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic [qir_pkg::ACC_W-1:0]  quo
);

  localparam int AW    = qir_pkg::ACC_W;
  localparam int CNT_W = $clog2(AW);

  qir_pkg::qir_unit_state_t state_r, state_nxt;
  logic [AW-1:0]    q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    quo_r, quo_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem_r, q_r[AW-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    case (state_r)
      qir_pkg::SU_IDLE: begin
        if (start) begin
          neg_nxt   = num[AW-1];
          q_nxt     = num[AW-1] ? (~num + 1'b1) : num;
          rem_nxt   = '0;
          den_nxt   = den;
          cnt_nxt   = CNT_W'(AW - 1);
          state_nxt = qir_pkg::SU_RUN;
        end
      end
      qir_pkg::SU_RUN: begin
        rem_nxt = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        q_nxt   = {q_r[AW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = qir_pkg::SU_FIN;
        end
      end
      qir_pkg::SU_FIN: begin
        quo_nxt   = neg_r ? (~q_r + 1'b1) : q_r;
        done_nxt  = 1'b1;
        state_nxt = qir_pkg::SU_IDLE;
      end
      default: state_nxt = qir_pkg::SU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qir_pkg::SU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/qir_acc.sv =====
// ----------------------------------------------------------------------------
// qir_acc
// Level, slope and curvature registers with digit-serial saturating updates.
// ----------------------------------------------------------------------------
module qir_acc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qir_pkg::qir_acc_ctl_t      ctl,
  input  logic [qir_pkg::ACC_W-1:0]  level_in,
  input  logic [qir_pkg::ACC_W-1:0]  curv_in,
  output logic [qir_pkg::ACC_W-1:0]  level,
  output logic [qir_pkg::ACC_W-1:0]  slope,
  output logic                       done
);

  localparam int AW     = qir_pkg::ACC_W;
  localparam int DW     = qir_pkg::DIGIT_W;
  localparam int NDIG   = AW / DW;
  localparam int DCNT_W = $clog2(NDIG);

  qir_pkg::qir_acc_state_t state_r, state_nxt;
  logic [AW-1:0]     level_r, level_nxt;
  logic [AW-1:0]     slope_r, slope_nxt;
  logic [AW-1:0]     curv_r, curv_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              carry_r, carry_nxt;
  logic              sa_r, sa_nxt;
  logic              sb_r, sb_nxt;
  logic              done_r, done_nxt;
  logic [AW-1:0]     op_a;
  logic [AW-1:0]     op_b;
  logic              cin;
  logic [DW:0]       dsum;
  logic [AW-1:0]     rot_a;
  logic [AW-1:0]     rot_b;
  logic              last_dig;

  always_comb begin
    if (state_r == qir_pkg::AC_LEVEL) begin
      op_a = level_r;
      op_b = slope_r;
    end else begin
      op_a = slope_r;
      op_b = curv_r;
    end
  end

  assign cin      = (cnt_r == '0) ? 1'b0 : carry_r;
  assign dsum     = {1'b0, op_a[DW-1:0]} + {1'b0, op_b[DW-1:0]} + {{DW{1'b0}}, cin};
  assign rot_a    = {dsum[DW-1:0], op_a[AW-1:DW]};
  assign rot_b    = {op_b[DW-1:0], op_b[AW-1:DW]};
  assign last_dig = cnt_r == DCNT_W'(NDIG - 1);

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    slope_nxt = slope_r;
    curv_nxt  = curv_r;
    cnt_nxt   = cnt_r;
    carry_nxt = carry_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    done_nxt  = 1'b0;
    case (state_r)
      qir_pkg::AC_IDLE: begin
        if (ctl.level_ld) begin
          level_nxt = level_in;
        end
        if (ctl.curv_ld) begin
          curv_nxt = curv_in;
        end
        if (ctl.start) begin
          cnt_nxt   = '0;
          state_nxt = qir_pkg::AC_SLOPE;
        end
      end
      qir_pkg::AC_SLOPE: begin
        slope_nxt = rot_a;
        curv_nxt  = rot_b;
        carry_nxt = dsum[DW];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          sa_nxt = op_a[AW-1];
          sb_nxt = op_b[AW-1];
        end
        if (last_dig) begin
          state_nxt = qir_pkg::AC_SFIX;
        end
      end
      qir_pkg::AC_SFIX: begin
        if (sa_r == sb_r && slope_r[AW-1] != sa_r) begin
          slope_nxt = qir_pkg::sat_value(sa_r);
        end
        cnt_nxt   = '0;
        state_nxt = qir_pkg::AC_LEVEL;
      end
      qir_pkg::AC_LEVEL: begin
        level_nxt = rot_a;
        slope_nxt = rot_b;
        carry_nxt = dsum[DW];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          sa_nxt = op_a[AW-1];
          sb_nxt = op_b[AW-1];
        end
        if (last_dig) begin
          state_nxt = qir_pkg::AC_LFIX;
        end
      end
      qir_pkg::AC_LFIX: begin
        if (sa_r == sb_r && level_r[AW-1] != sa_r) begin
          level_nxt = qir_pkg::sat_value(sa_r);
        end
        done_nxt  = 1'b1;
        state_nxt = qir_pkg::AC_IDLE;
      end
      default: state_nxt = qir_pkg::AC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qir_pkg::AC_IDLE;
      level_r <= '0;
      slope_r <= '0;
      curv_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      slope_r <= slope_nxt;
      curv_r  <= curv_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    carry_r <= carry_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
  end

  assign level = level_r;
  assign slope = slope_r;
  assign done  = done_r;

endmodule

// ===== design/quadratic_interp_random_ramp_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_interp_random_ramp_core
// Smooth random ramp: quadratic segments between midpoints of random points.
// ----------------------------------------------------------------------------
// Sequencing: an item inside a segment runs two 16-digit passes of the 4-bit
//   serial adder (slope, then level); an item that opens a segment first runs
//   the bit-serial length multiply and the 64-step divide.
// Throughput: one item in flight; the next transfer can be taken in the same
//   cycle the result goes valid, once the output register is free.
// Reset: state clears, length returns to 441, the first item opens a segment.
module quadratic_interp_random_ramp_core #(
  parameter int LENGTH_BITS = qir_pkg::LENGTH_BITS_DEF,
  parameter int SAMPLE_BITS = qir_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qir_in_if.sink     in_port,
  qir_out_if.source  out_port,
  qir_cfg_if.sink    cfg_port
);

  localparam int AW        = qir_pkg::ACC_W;
  localparam int PW        = qir_pkg::POINT_W;
  localparam int MW        = qir_pkg::MID_W;
  localparam int MS        = qir_pkg::MID_SHIFT;
  localparam int DEN_W     = 2 * LENGTH_BITS - 1;
  localparam int PROD_W    = 2 * LENGTH_BITS + 1;
  localparam int OUT_SHIFT = AW - 3 - SAMPLE_BITS;
  localparam int RND_W     = AW - OUT_SHIFT + 1;

  qir_pkg::qir_state_t state_r, state_nxt;
  logic [LENGTH_BITS-1:0] seg_len_r, seg_len_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [PW-1:0]          point_r, point_nxt;
  logic [MW-1:0]          mid_r, mid_nxt;
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic [AW-1:0]          num1_r, num1_nxt;
  logic [AW-1:0]          num_r, num_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic                   in_xfer;
  logic                   seg_start;
  logic [LENGTH_BITS-1:0] len_eff;
  logic [LENGTH_BITS:0]   len_p1;
  logic [PROD_W-1:0]      den_full;
  logic [MW-1:0]          mid_new;
  logic [MW:0]            mid_diff;
  logic [AW-1:0]          level_seg;
  logic [AW-1:0]          num_diff;
  logic                   num_ovf;
  logic [RND_W-1:0]       rnd;
  logic                   rnd_in_range;
  logic [SAMPLE_BITS-1:0] sample_val;

  logic                   mul_start;
  logic                   mul_done;
  logic [AW-1:0]          mul_prod;
  logic                   div_start;
  logic                   div_done;
  logic [AW-1:0]          div_quo;
  qir_pkg::qir_acc_ctl_t  acc_ctl;
  logic [AW-1:0]          acc_level;
  logic [AW-1:0]          acc_slope;
  logic                   acc_done;

  assign in_port.ready  = state_r == qir_pkg::ST_IDLE;
  assign in_xfer        = in_port.valid & in_port.ready;
  assign cfg_port.ready = 1'b1;

  assign seg_start = left_r == '0;
  assign len_eff   = (seg_len_r < LENGTH_BITS'(qir_pkg::MIN_LEN)) ?
                     LENGTH_BITS'(qir_pkg::MIN_LEN) : seg_len_r;
  assign len_p1    = {1'b0, len_eff} + 1'b1;
  assign den_full  = PROD_W'(len_eff) * PROD_W'(len_p1);

  assign mid_new   = {point_r[PW-1], point_r} +
                     {in_port.random_point[PW-1], in_port.random_point};
  assign mid_diff  = {mid_new[MW-1], mid_new} - {mid_r[MW-1], mid_r};
  assign level_seg = {{(AW-MS-MW){mid_r[MW-1]}}, mid_r, {MS{1'b0}}};

  assign num_diff = num1_r - mul_prod;
  assign num_ovf  = (num1_r[AW-1] != mul_prod[AW-1]) && (num_diff[AW-1] != num1_r[AW-1]);

  assign rnd          = {acc_level[AW-1], acc_level[AW-1:OUT_SHIFT]} +
                        RND_W'(acc_level[OUT_SHIFT-1]);
  assign rnd_in_range = (&rnd[RND_W-1:SAMPLE_BITS-1]) | ~(|rnd[RND_W-1:SAMPLE_BITS-1]);
  assign sample_val   = rnd_in_range ? rnd[SAMPLE_BITS-1:0] :
                        (rnd[RND_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                                        {1'b0, {(SAMPLE_BITS-1){1'b1}}});

  always_comb begin
    state_nxt     = state_r;
    seg_len_nxt   = seg_len_r;
    left_nxt      = left_r;
    point_nxt     = point_r;
    mid_nxt       = mid_r;
    den_nxt       = den_r;
    num1_nxt      = num1_r;
    num_nxt       = num_r;
    sample_nxt    = sample_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_port.ready;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    acc_ctl       = '0;

    if (cfg_port.valid) begin
      seg_len_nxt = cfg_port.segment_length;
    end

    case (state_r)
      qir_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (seg_start) begin
            point_nxt        = in_port.random_point;
            mid_nxt          = mid_new;
            den_nxt          = den_full[DEN_W:1];
            num1_nxt         = {{(AW-MS-MW-1){mid_diff[MW]}}, mid_diff, {MS{1'b0}}};
            left_nxt         = len_eff - 1'b1;
            acc_ctl.level_ld = 1'b1;
            mul_start        = 1'b1;
            state_nxt        = qir_pkg::ST_MUL;
          end else begin
            left_nxt  = left_r - 1'b1;
            state_nxt = qir_pkg::ST_SAMPLE;
          end
        end
      end
      qir_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = qir_pkg::ST_SUB;
        end
      end
      qir_pkg::ST_SUB: begin
        num_nxt   = num_ovf ? qir_pkg::sat_value(num1_r[AW-1]) : num_diff;
        state_nxt = qir_pkg::ST_DSTART;
      end
      qir_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = qir_pkg::ST_DIV;
      end
      qir_pkg::ST_DIV: begin
        if (div_done) begin
          acc_ctl.curv_ld = 1'b1;
          state_nxt       = qir_pkg::ST_SAMPLE;
        end
      end
      qir_pkg::ST_SAMPLE: begin
        sample_nxt    = sample_val;
        acc_ctl.start = 1'b1;
        state_nxt     = qir_pkg::ST_ACC;
      end
      qir_pkg::ST_ACC: begin
        if (acc_done) begin
          state_nxt = qir_pkg::ST_EMIT;
        end
      end
      qir_pkg::ST_EMIT: begin
        if (!out_valid_r || out_port.ready) begin
          out_data_nxt  = sample_r;
          out_valid_nxt = 1'b1;
          state_nxt     = qir_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qir_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qir_pkg::ST_IDLE;
      seg_len_r   <= LENGTH_BITS'(qir_pkg::SEG_LEN_RESET);
      left_r      <= '0;
      point_r     <= '0;
      mid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_len_r   <= seg_len_nxt;
      left_r      <= left_nxt;
      point_r     <= point_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r      <= den_nxt;
    num1_r     <= num1_nxt;
    num_r      <= num_nxt;
    sample_r   <= sample_nxt;
    out_data_r <= out_data_nxt;
  end

  qir_lenmul #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_lenmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .slope (acc_slope),
    .len   (len_eff),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  qir_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  qir_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .level_in (level_seg),
    .curv_in  (div_quo),
    .level    (acc_level),
    .slope    (acc_slope),
    .done     (acc_done)
  );

  assign out_port.valid         = out_valid_r;
  assign out_port.output_sample = out_data_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives random points into the quadratic ramp and checks every sample against
// a cycle-free model of the segment math: midpoint steps, curvature solve,
// saturating slope and level updates, and rounding of the output sample.
// Segment lengths run from the short corner cases to the largest value.
// ----------------------------------------------------------------------------
module testbench;

  import qir_pkg::*;

  localparam int          SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int          LEN_W       = LENGTH_BITS_DEF;
  localparam int          OUT_SHIFT   = 61 - SAMPLE_W;
  localparam longint      SMP_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint      SMP_MIN     = -SMP_MAX - 1;
  localparam int          ITEM_TARGET = 1920;
  localparam int          TAIL_ROOM   = 400;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          DRAIN_WAIT  = 300;
  localparam int unsigned REPORT_MAX  = 10;

  localparam logic [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};
  localparam logic [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};

  logic clk;
  logic rst_n;

  qir_in_if  in_if ();
  qir_out_if out_if ();
  qir_cfg_if cfg_if ();

  quadratic_interp_random_ramp_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // model state
  logic [LEN_W-1:0] seg_length      = LEN_W'(SEG_LEN_RESET);
  longint           ramp_level      = 0;
  longint           ramp_slope      = 0;
  longint           ramp_curv       = 0;
  longint           last_point      = 0;
  longint           last_mid        = 0;
  int unsigned      left_in_segment = 0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  int unsigned         mismatches   = 0;
  int unsigned         items_sent   = 0;
  int unsigned         burst_left   = 0;
  int unsigned         rx_cycle     = 0;
  int unsigned         quiet_cycles = 0;

  function automatic longint clamp_acc(input logic signed [95:0] v);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = $signed({32'd0, ACC_MAX});
    lo = $signed({{32{1'b1}}, ACC_MIN});
    if (v > hi) return $signed(ACC_MAX);
    if (v < lo) return $signed(ACC_MIN);
    return v[63:0];
  endfunction

  function automatic longint sat_sum(input logic signed [95:0] a, input logic signed [95:0] b);
    return clamp_acc(a + b);
  endfunction

  function automatic longint sat_diff(input logic signed [95:0] a, input logic signed [95:0] b);
    return clamp_acc(a - b);
  endfunction

  function automatic longint sat_scale(input logic signed [95:0] v, input logic signed [95:0] n);
    return clamp_acc(v * n);
  endfunction

  function automatic logic [SAMPLE_W-1:0] round_sample(input longint v);
    longint r;
    r = sat_sum(v, longint'(1) <<< (OUT_SHIFT - 1)) >>> OUT_SHIFT;
    if (r > SMP_MAX) r = SMP_MAX;
    if (r < SMP_MIN) r = SMP_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic advance_ramp(input logic [POINT_W-1:0] p, output logic [SAMPLE_W-1:0] s);
    longint prev;
    longint run;
    longint den;
    longint num;
    if (left_in_segment == 0) begin
      prev = last_point;
      run = (seg_length < MIN_LEN) ? longint'(MIN_LEN) : longint'(seg_length);
      den = run * (run + 1) / 2;
      last_point = longint'($signed(p));
      ramp_level = last_mid <<< MID_SHIFT;
      last_mid = prev + last_point;
      num = sat_diff(last_mid <<< MID_SHIFT, ramp_level);
      num = sat_diff(num, sat_scale(ramp_slope, run));
      ramp_curv = num / den;
      left_in_segment = 32'(run);
    end
    left_in_segment--;
    s = round_sample(ramp_level);
    ramp_slope = sat_sum(ramp_slope, ramp_curv);
    ramp_level = sat_sum(ramp_level, ramp_slope);
  endtask

  function automatic logic [POINT_W-1:0] pick_point();
    case ($urandom_range(0, 9))
      0: return POINT_MIN;
      1: return POINT_MAX;
      2: return {POINT_W{1'b1}} - POINT_W'($urandom_range(0, 15));
      3: return POINT_W'($urandom_range(0, 15));
      default: return POINT_W'($urandom);
    endcase
  endfunction

  // one transfer on the point channel; valid stays high while the burst lasts
  task automatic send_point(input logic [POINT_W-1:0] p);
    logic [SAMPLE_W-1:0] s;
    in_if.valid        <= 1'b1;
    in_if.random_point <= p;
    do @(posedge clk); while (!in_if.ready);
    advance_ramp(p, s);
    pending_samples.push_back(s);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      case ($urandom_range(0, 3))
        0: burst_left = 0;
        1: burst_left = $urandom_range(1, 4);
        2: burst_left = $urandom_range(5, 20);
        default: burst_left = $urandom_range(30, 80);
      endcase
    end
  endtask

  task automatic finish_segment();
    do send_point(pick_point()); while (left_in_segment != 0);
  endtask

  task automatic write_segment_length(input logic [LEN_W-1:0] v);
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    cfg_if.valid          <= 1'b1;
    cfg_if.segment_length <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    seg_length = v;
  endtask

  // short segments with extreme points build up a steep slope
  task automatic swing_segments(input int unsigned count);
    write_segment_length(LEN_W'(MIN_LEN));
    for (int unsigned i = 0; i < count; i++) begin
      send_point(i[1] ? POINT_MIN : POINT_MAX);
      finish_segment();
    end
  endtask

  task automatic test_default_segment();
    send_point(POINT_MAX);
    while (left_in_segment != 0) send_point(pick_point());
  endtask

  task automatic test_short_lengths();
    logic [POINT_W-1:0] corner_pts[4];
    corner_pts = '{POINT_MIN, POINT_MAX, '0, '1};
    for (int unsigned len = 0; len < 4; len++) begin
      write_segment_length(LEN_W'(len));
      do send_point(corner_pts[items_sent % 4]); while (left_in_segment != 0);
    end
  endtask

  task automatic test_overshoot();
    swing_segments(6);
    write_segment_length(LEN_W'(96));
    finish_segment();
  endtask

  task automatic test_random_lengths();
    logic [LEN_W-1:0] len;
    int unsigned      segs;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0:       len = LEN_W'($urandom_range(0, 1));
        1, 2:    len = LEN_W'($urandom_range(2, 4));
        11, 12:  len = LEN_W'($urandom_range(13, 64));
        13:      len = LEN_W'($urandom_range(65, 300));
        default: len = LEN_W'($urandom_range(2, 12));
      endcase
      if (items_sent + TAIL_ROOM > ITEM_TARGET) len = LEN_W'($urandom_range(2, 12));
      write_segment_length(len);
      segs = (len > 64) ? 1 : $urandom_range(1, 6);
      repeat (segs) finish_segment();
    end
  endtask

  task automatic test_longest_segment();
    swing_segments(4);
    write_segment_length('1);
    repeat (3) send_point(pick_point());
  endtask

  // result side: check, then pick the next ready value
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected sample %0d", $signed(out_if.output_sample));
      end else begin
        want = pending_samples.pop_front();
        if (out_if.output_sample !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("sample mismatch: expected %0d, got %0d",
                     $signed(want), $signed(out_if.output_sample));
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0:    out_if.ready <= 1'b1;
      2'd1:    out_if.ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_if.ready <= ($urandom_range(0, 7) == 0);
      default: out_if.ready <= (rx_cycle[4:3] == 2'd0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.random_point    <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.segment_length <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_segment();
    test_short_lengths();
    test_overshoot();
    test_random_lengths();
    test_longest_segment();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
